// File: design/assert_macros.svh
// Shared assertion macros. Both sample on clk and are disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define RIE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication.
`define RIE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: design/rie_pkg.sv
`default_nettype none

package rie_pkg;

    localparam int DATA_DEPTH_DEF = 4096;
    localparam int NUM_IO_DEF     = 23;
    localparam int NUM_REGS       = 16;
    localparam int REG_AW         = 4;
    localparam int XLEN           = 32;
    localparam int PC_W           = 12;
    localparam int MADDR_W        = 12;
    localparam int IMM_W          = 12;
    localparam int INSTR_W        = 48;
    localparam int IO_IDX_W       = 5;
    localparam int IO_RETI_IDX    = 7;

    localparam logic [1:0] FN_EXEC = 2'd0;
    localparam logic [1:0] FN_MWR  = 2'd1;
    localparam logic [1:0] FN_MRD  = 2'd2;
    localparam logic [1:0] FN_RREG = 2'd3;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_HALT    = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    localparam logic [7:0] OP_ADD  = 8'd0;
    localparam logic [7:0] OP_SUB  = 8'd1;
    localparam logic [7:0] OP_MAC  = 8'd2;
    localparam logic [7:0] OP_AND  = 8'd3;
    localparam logic [7:0] OP_OR   = 8'd4;
    localparam logic [7:0] OP_XOR  = 8'd5;
    localparam logic [7:0] OP_SLL  = 8'd6;
    localparam logic [7:0] OP_SRA  = 8'd7;
    localparam logic [7:0] OP_SRL  = 8'd8;
    localparam logic [7:0] OP_BEQ  = 8'd9;
    localparam logic [7:0] OP_BNE  = 8'd10;
    localparam logic [7:0] OP_BLT  = 8'd11;
    localparam logic [7:0] OP_BGT  = 8'd12;
    localparam logic [7:0] OP_BLE  = 8'd13;
    localparam logic [7:0] OP_BGE  = 8'd14;
    localparam logic [7:0] OP_JAL  = 8'd15;
    localparam logic [7:0] OP_LW   = 8'd16;
    localparam logic [7:0] OP_SW   = 8'd17;
    localparam logic [7:0] OP_RETI = 8'd18;
    localparam logic [7:0] OP_IN   = 8'd19;
    localparam logic [7:0] OP_OUT  = 8'd20;
    localparam logic [7:0] OP_HALT = 8'd21;

    function automatic logic [XLEN-1:0] sext12(input logic [IMM_W-1:0] v);
        return {{(XLEN-IMM_W){v[IMM_W-1]}}, v};
    endfunction

endpackage

`default_nettype wire

// File: design/rie_ram.sv
`default_nettype none

module rie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: design/risc_instruction_execute_core.sv
`default_nettype none

// Small RISC execute core. Each accepted word either executes one 48-bit instruction
// or preloads, reads back or inspects state; every word yields exactly one result word
// through the v1 and v2 stages and the output registers. The register file sits in four
// copies of a 16-entry RAM (one read port per operand) and the data memory in one RAM,
// both with registered reads. The core accepts one word per cycle unless the output
// stalls, which freezes the whole pipeline, or a lw sits in v1, as the loaded value then
// comes back from the data memory for writeback. No clearing pass is needed after reset.

module risc_instruction_execute_core #(
    parameter int DATA_DEPTH = rie_pkg::DATA_DEPTH_DEF,
    parameter int NUM_IO     = rie_pkg::NUM_IO_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    func,
    input  logic [rie_pkg::INSTR_W-1:0]   instr_word,
    input  logic [rie_pkg::MADDR_W-1:0]   mem_address,
    input  logic [rie_pkg::XLEN-1:0]      write_value,
    input  logic [rie_pkg::REG_AW-1:0]    reg_index,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic [rie_pkg::PC_W-1:0]      pc_now,
    output logic [rie_pkg::XLEN-1:0]      read_value,
    output logic                          io_read,
    output logic                          io_write,
    output logic [rie_pkg::IO_IDX_W-1:0]  io_index,
    output logic [rie_pkg::XLEN-1:0]      io_value
);

    import rie_pkg::*;

    localparam int DAW = $clog2(DATA_DEPTH);
    localparam int IOW = $clog2(NUM_IO);

    function automatic logic [DAW-1:0] dmod(input logic [MADDR_W-1:0] v);
        logic [15:0] r;
        r = 16'(v);
        for (int k = 3; k >= 0; k--)
        begin
            if (r >= 16'(DATA_DEPTH << k))
            begin
                r = r - 16'(DATA_DEPTH << k);
            end
        end
        return r[DAW-1:0];
    endfunction

    logic advance;
    logic accept;

    logic                   v1_valid_reg;
    logic [1:0]             v1_func_reg;
    logic [INSTR_W-1:0]     v1_instr_reg;
    logic [MADDR_W-1:0]     v1_maddr_reg;
    logic [XLEN-1:0]        v1_wval_reg;
    logic [REG_AW-1:0]      v1_ridx_reg;

    logic                   v2_valid_reg;
    logic                   v2_lw_reg;
    logic                   v2_mrd_reg;
    logic [REG_AW-1:0]      v2_rd_reg;
    logic [XLEN-1:0]        v2_c_reg;
    logic [1:0]             v2_status_reg;
    logic [PC_W-1:0]        v2_pc_reg;
    logic [XLEN-1:0]        v2_rv_reg;
    logic                   v2_ior_reg;
    logic                   v2_iow_reg;
    logic [IO_IDX_W-1:0]    v2_ioi_reg;
    logic [XLEN-1:0]        v2_iov_reg;

    logic                   out_valid_reg;
    logic [1:0]             status_reg;
    logic [PC_W-1:0]        pc_now_reg;
    logic [XLEN-1:0]        read_value_reg;
    logic                   io_read_reg;
    logic                   io_write_reg;
    logic [IO_IDX_W-1:0]    io_index_reg;
    logic [XLEN-1:0]        io_value_reg;

    logic [PC_W-1:0]        pc_reg;
    logic [PC_W-1:0]        pc_next;
    logic [XLEN-1:0]        r1_reg;
    logic [XLEN-1:0]        r1_next;
    logic [XLEN-1:0]        r2_reg;
    logic [XLEN-1:0]        r2_next;
    logic [NUM_REGS-1:0]    vld_reg;
    logic [XLEN-1:0]        io_regs_reg [NUM_IO];

    logic                   fwd_en_reg;
    logic [REG_AW-1:0]      fwd_addr_reg;
    logic [XLEN-1:0]        fwd_data_reg;

    logic [REG_AW-1:0]      ra_addr;
    logic [XLEN-1:0]        ram_a;
    logic [XLEN-1:0]        ram_b;
    logic [XLEN-1:0]        ram_c;
    logic [XLEN-1:0]        ram_d;

    logic                   rf_we;
    logic                   wr_any;
    logic [REG_AW-1:0]      wr_idx;
    logic [XLEN-1:0]        wr_val;

    logic [7:0]             op;
    logic [REG_AW-1:0]      rd;
    logic [REG_AW-1:0]      rs;
    logic [REG_AW-1:0]      rt;
    logic [REG_AW-1:0]      rm;
    logic                   is_exec;
    logic                   op_valid;
    logic                   exec_ok;
    logic                   v1_is_lw;
    logic [XLEN-1:0]        r1v;
    logic [XLEN-1:0]        r2v;
    logic [XLEN-1:0]        a;
    logic [XLEN-1:0]        b;
    logic [XLEN-1:0]        c;
    logic [XLEN-1:0]        d;
    logic [XLEN-1:0]        sum;
    logic                   io_hit;
    logic [IOW-1:0]         io_sel;
    logic [XLEN-1:0]        iov;
    logic [XLEN-1:0]        rd_val;
    logic                   rd_we;
    logic                   jump;
    logic [PC_W-1:0]        pc_step;
    logic [1:0]             st;
    logic                   x_wb;
    logic                   lw_wb;

    logic                   dm_we;
    logic                   dm_re;
    logic [DAW-1:0]         dm_addr;
    logic [XLEN-1:0]        dm_wdata;
    logic [XLEN-1:0]        dm_rdata;

    assign advance  = !out_valid_reg || !out_stall;
    assign v1_is_lw = (v1_func_reg == FN_EXEC) && (v1_instr_reg[47:40] == OP_LW);
    // A load writes back from v2 rather than v1, so nothing enters behind it while it sits in v1.
    assign in_stall = !advance || (v1_valid_reg && v1_is_lw);
    assign accept   = in_valid && !in_stall;

    assign ra_addr = (func == FN_RREG) ? reg_index : instr_word[35:32];

    rie_ram #(.WIDTH(XLEN), .DEPTH(NUM_REGS)) u_rf_a (
        .clk(clk), .we(rf_we), .waddr(wr_idx), .wdata(wr_val),
        .re(accept), .raddr(ra_addr), .rdata(ram_a)
    );
    rie_ram #(.WIDTH(XLEN), .DEPTH(NUM_REGS)) u_rf_b (
        .clk(clk), .we(rf_we), .waddr(wr_idx), .wdata(wr_val),
        .re(accept), .raddr(instr_word[31:28]), .rdata(ram_b)
    );
    rie_ram #(.WIDTH(XLEN), .DEPTH(NUM_REGS)) u_rf_c (
        .clk(clk), .we(rf_we), .waddr(wr_idx), .wdata(wr_val),
        .re(accept), .raddr(instr_word[27:24]), .rdata(ram_c)
    );
    rie_ram #(.WIDTH(XLEN), .DEPTH(NUM_REGS)) u_rf_d (
        .clk(clk), .we(rf_we), .waddr(wr_idx), .wdata(wr_val),
        .re(accept), .raddr(instr_word[39:36]), .rdata(ram_d)
    );

    rie_ram #(.WIDTH(XLEN), .DEPTH(DATA_DEPTH)) u_dmem (
        .clk(clk), .we(dm_we), .waddr(dm_addr), .wdata(dm_wdata),
        .re(dm_re), .raddr(dm_addr), .rdata(dm_rdata)
    );

    assign op      = v1_instr_reg[47:40];
    assign rd      = v1_instr_reg[39:36];
    assign rs      = v1_instr_reg[35:32];
    assign rt      = v1_instr_reg[31:28];
    assign rm      = v1_instr_reg[27:24];
    assign is_exec = (v1_func_reg == FN_EXEC);
    assign op_valid = (op <= OP_HALT);
    assign exec_ok = is_exec && op_valid;

    // r1 and r2 read as this instruction's immediates; a register read sees the held values.
    assign r1v = is_exec ? sext12(v1_instr_reg[23:12]) : r1_reg;
    assign r2v = is_exec ? sext12(v1_instr_reg[11:0]) : r2_reg;

    // The RAM read was captured at the same edge as the last write, so that write is forwarded.
    function automatic logic [XLEN-1:0] opnd(input logic [REG_AW-1:0] idx,
                                             input logic [XLEN-1:0] ram);
        logic [XLEN-1:0] v;
        priority if (idx == REG_AW'(0))
            v = '0;
        else if (idx == REG_AW'(1))
            v = r1v;
        else if (idx == REG_AW'(2))
            v = r2v;
        else if (fwd_en_reg && (fwd_addr_reg == idx))
            v = fwd_data_reg;
        else if (vld_reg[idx])
            v = ram;
        else
            v = '0;
        return v;
    endfunction

    always_comb
    begin
        a = opnd((v1_func_reg == FN_RREG) ? v1_ridx_reg : rs, ram_a);
        b = opnd(rt, ram_b);
        c = opnd(rm, ram_c);
        d = opnd(rd, ram_d);
    end

    assign sum = a + b;

    assign io_hit = (sum < XLEN'(NUM_IO));
    assign io_sel = sum[IOW-1:0];
    assign iov    = io_hit ? io_regs_reg[io_sel] : '0;

    always_comb
    begin
        rd_val = '0;
        rd_we  = 1'b0;
        jump   = 1'b0;
        unique case (op)
            OP_ADD:  begin rd_val = a + b + c; rd_we = 1'b1; end
            OP_SUB:  begin rd_val = a - b - c; rd_we = 1'b1; end
            OP_MAC:  begin rd_val = (a * b) + c; rd_we = 1'b1; end
            OP_AND:  begin rd_val = a & b & c; rd_we = 1'b1; end
            OP_OR:   begin rd_val = a | b | c; rd_we = 1'b1; end
            OP_XOR:  begin rd_val = a ^ b ^ c; rd_we = 1'b1; end
            OP_SLL:
            begin
                rd_val = (b >= XLEN'(32)) ? '0 : (a << b[4:0]);
                rd_we  = 1'b1;
            end
            OP_SRA:
            begin
                rd_val = (b >= XLEN'(32)) ? {XLEN{a[XLEN-1]}}
                                          : XLEN'($signed(a) >>> b[4:0]);
                rd_we  = 1'b1;
            end
            OP_SRL:
            begin
                rd_val = (b >= XLEN'(32)) ? '0 : (a >> b[4:0]);
                rd_we  = 1'b1;
            end
            OP_BEQ:  jump = (a == b);
            OP_BNE:  jump = (a != b);
            OP_BLT:  jump = ($signed(a) < $signed(b));
            OP_BGT:  jump = ($signed(a) > $signed(b));
            OP_BLE:  jump = ($signed(a) <= $signed(b));
            OP_BGE:  jump = ($signed(a) >= $signed(b));
            OP_JAL:
            begin
                rd_val = XLEN'(pc_reg + PC_W'(1));
                rd_we  = 1'b1;
                jump   = 1'b1;
            end
            OP_IN:
            begin
                rd_val = iov;
                rd_we  = io_hit;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        pc_step = pc_reg;
        st      = ST_DONE;
        if (is_exec)
        begin
            if (!op_valid)
            begin
                st = ST_INVALID;
            end
            else if (op == OP_HALT)
            begin
                st = ST_HALT;
            end
            else if (op == OP_RETI)
            begin
                pc_step = io_regs_reg[IO_RETI_IDX][PC_W-1:0];
            end
            else if (jump)
            begin
                pc_step = c[PC_W-1:0];
            end
            else
            begin
                pc_step = pc_reg + PC_W'(1);
            end
        end
    end

    assign x_wb   = v1_valid_reg && exec_ok && rd_we;
    assign lw_wb  = v2_valid_reg && v2_lw_reg;
    assign wr_idx = lw_wb ? v2_rd_reg : rd;
    assign wr_val = lw_wb ? (dm_rdata + v2_c_reg) : rd_val;
    assign wr_any = advance && (lw_wb || x_wb);
    assign rf_we  = wr_any && (wr_idx != REG_AW'(0)) && (wr_idx != REG_AW'(1))
                    && (wr_idx != REG_AW'(2));

    assign dm_addr  = is_exec ? dmod(sum[MADDR_W-1:0]) : dmod(v1_maddr_reg);
    assign dm_wdata = is_exec ? (c + d) : v1_wval_reg;
    assign dm_we    = advance && v1_valid_reg
                      && ((v1_func_reg == FN_MWR) || (exec_ok && op == OP_SW));
    assign dm_re    = advance && v1_valid_reg && ((v1_func_reg == FN_MRD) || v1_is_lw);

    always_comb
    begin
        r1_next = r1_reg;
        r2_next = r2_reg;
        if (advance && v1_valid_reg && exec_ok)
        begin
            r1_next = r1v;
            r2_next = r2v;
        end
        if (wr_any && (wr_idx == REG_AW'(1)))
        begin
            r1_next = wr_val;
        end
        if (wr_any && (wr_idx == REG_AW'(2)))
        begin
            r2_next = wr_val;
        end
    end

    assign pc_next = (advance && v1_valid_reg) ? pc_step : pc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_valid_reg  <= 1'b0;
            v2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pc_reg        <= '0;
            r1_reg        <= '0;
            r2_reg        <= '0;
            vld_reg       <= '0;
            fwd_en_reg    <= 1'b0;
            for (int i = 0; i < NUM_IO; i++)
            begin
                io_regs_reg[i] <= '0;
            end
        end
        else
        begin
            pc_reg <= pc_next;
            r1_reg <= r1_next;
            r2_reg <= r2_next;
            if (rf_we)
            begin
                vld_reg[wr_idx] <= 1'b1;
            end
            if (advance)
            begin
                v1_valid_reg  <= accept;
                v2_valid_reg  <= v1_valid_reg;
                out_valid_reg <= v2_valid_reg;
                fwd_en_reg    <= rf_we;
                if (v1_valid_reg && exec_ok && (op == OP_OUT) && io_hit)
                begin
                    io_regs_reg[io_sel] <= c;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            v1_func_reg  <= func;
            v1_instr_reg <= instr_word;
            v1_maddr_reg <= mem_address;
            v1_wval_reg  <= write_value;
            v1_ridx_reg  <= reg_index;
        end
        if (advance)
        begin
            fwd_addr_reg  <= wr_idx;
            fwd_data_reg  <= wr_val;
            v2_lw_reg     <= v1_is_lw;
            v2_mrd_reg    <= (v1_func_reg == FN_MRD);
            v2_rd_reg     <= rd;
            v2_c_reg      <= c;
            v2_status_reg <= st;
            v2_pc_reg     <= pc_step;
            v2_rv_reg     <= (v1_func_reg == FN_RREG) ? a : '0;
            v2_ior_reg    <= exec_ok && (op == OP_IN) && io_hit;
            v2_iow_reg    <= exec_ok && (op == OP_OUT) && io_hit;
            v2_ioi_reg    <= (exec_ok && io_hit && (op == OP_IN || op == OP_OUT))
                             ? IO_IDX_W'(io_sel) : '0;
            v2_iov_reg    <= (exec_ok && io_hit && op == OP_IN) ? iov
                             : ((exec_ok && io_hit && op == OP_OUT) ? c : '0);

            status_reg     <= v2_status_reg;
            pc_now_reg     <= v2_pc_reg;
            read_value_reg <= v2_mrd_reg ? dm_rdata : v2_rv_reg;
            io_read_reg    <= v2_ior_reg;
            io_write_reg   <= v2_iow_reg;
            io_index_reg   <= v2_ioi_reg;
            io_value_reg   <= v2_iov_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign pc_now     = pc_now_reg;
    assign read_value = read_value_reg;
    assign io_read    = io_read_reg;
    assign io_write   = io_write_reg;
    assign io_index   = io_index_reg;
    assign io_value   = io_value_reg;

endmodule

`default_nettype wire

// File: design/rie_checker.sv
`default_nettype none

`include "assert_macros.svh"

module rie_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic [1:0]                    status,
    input wire logic [rie_pkg::PC_W-1:0]      pc_now,
    input wire logic [rie_pkg::XLEN-1:0]      read_value,
    input wire logic                          io_read,
    input wire logic                          io_write,
    input wire logic [rie_pkg::IO_IDX_W-1:0]  io_index,
    input wire logic [rie_pkg::XLEN-1:0]      io_value
);

    import rie_pkg::*;

    // Halt and invalid words carry no readback and no I/O traffic.
    `RIE_ASSERT_IMP(a_halt_quiet, out_valid && (status != ST_DONE),
                    (read_value == '0) && !io_read && !io_write)
    `RIE_ASSERT_IMP(a_io_excl, out_valid, !(io_read && io_write))
    `RIE_ASSERT_IMP(a_io_idle, out_valid && !io_read && !io_write,
                    (io_index == '0) && (io_value == '0))
    `RIE_ASSERT_NXT(a_out_hold, out_valid && out_stall,
                    out_valid && $stable(status) && $stable(pc_now) && $stable(read_value))

endmodule

bind risc_instruction_execute_core rie_checker u_rie_checker (
    .clk(clk),
    .rst_n(rst_n),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .pc_now(pc_now),
    .read_value(read_value),
    .io_read(io_read),
    .io_write(io_write),
    .io_index(io_index),
    .io_value(io_value)
);

`default_nettype wire

// File: verif/rie_checker.sv
`timescale 1ns / 1ps

module rie_scoreboard
    import rie_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [1:0]           func,
    input  logic [INSTR_W-1:0]   instr_word,
    input  logic [MADDR_W-1:0]   mem_address,
    input  logic [XLEN-1:0]      write_value,
    input  logic [REG_AW-1:0]    reg_index,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [1:0]           status,
    input  logic [PC_W-1:0]      pc_now,
    input  logic [XLEN-1:0]      read_value,
    input  logic                 io_read,
    input  logic                 io_write,
    input  logic [IO_IDX_W-1:0]  io_index,
    input  logic [XLEN-1:0]      io_value,
    output int                   fail_count,
    output int                   outstanding
);

    typedef struct packed {
        logic [1:0]          status;
        logic [PC_W-1:0]     pc_now;
        logic [XLEN-1:0]     read_value;
        logic                io_read;
        logic                io_write;
        logic [IO_IDX_W-1:0] io_index;
        logic [XLEN-1:0]     io_value;
    } core_result_t;

    logic [PC_W-1:0] pc_q;
    logic [XLEN-1:0] regs_q [NUM_REGS];
    logic [XLEN-1:0] dmem_q [DATA_DEPTH_DEF];
    logic [XLEN-1:0] io_q   [NUM_IO_DEF];
    core_result_t    expected_results [$];

    function automatic logic [XLEN-1:0] reg_rd(input logic [REG_AW-1:0] i);
        return (i == 0) ? '0 : regs_q[i];
    endfunction

    task automatic reg_wr(input logic [REG_AW-1:0] i, input logic [XLEN-1:0] v);
        if (i != 0)
            regs_q[i] = v;
    endtask

    // Advances the core state by one word and returns the result it should produce.
    task automatic execute_word(input logic [1:0] fn, input logic [INSTR_W-1:0] iw,
                                input logic [MADDR_W-1:0] addr, input logic [XLEN-1:0] wv,
                                input logic [REG_AW-1:0] ri, output core_result_t r);
        logic [7:0]        op;
        logic [REG_AW-1:0] rd, rs, rt, rm;
        logic [XLEN-1:0]   a, b, c, d, sum;
        logic              jump;
        op = iw[47:40];
        rd = iw[39:36];
        rs = iw[35:32];
        rt = iw[31:28];
        rm = iw[27:24];
        jump = 1'b0;
        r = '0;
        if (fn == FN_MWR)
            dmem_q[addr] = wv;
        else if (fn == FN_MRD)
            r.read_value = dmem_q[addr];
        else if (fn == FN_RREG)
            r.read_value = reg_rd(ri);
        else if (op > OP_HALT)
            r.status = ST_INVALID;
        else
        begin
            regs_q[1] = {{20{iw[23]}}, iw[23:12]};
            regs_q[2] = {{20{iw[11]}}, iw[11:0]};
            a = reg_rd(rs);
            b = reg_rd(rt);
            c = reg_rd(rm);
            d = reg_rd(rd);
            sum = a + b;
            case (op)
                OP_ADD:  reg_wr(rd, a + b + c);
                OP_SUB:  reg_wr(rd, a - b - c);
                OP_MAC:  reg_wr(rd, a * b + c);
                OP_AND:  reg_wr(rd, a & b & c);
                OP_OR:   reg_wr(rd, a | b | c);
                OP_XOR:  reg_wr(rd, a ^ b ^ c);
                OP_SLL:  reg_wr(rd, (b >= 32) ? '0 : a << b[4:0]);
                OP_SRA:  reg_wr(rd, (b >= 32) ? {XLEN{a[31]}} : XLEN'($signed(a) >>> b[4:0]));
                OP_SRL:  reg_wr(rd, (b >= 32) ? '0 : a >> b[4:0]);
                OP_BEQ:  jump = (a == b);
                OP_BNE:  jump = (a != b);
                OP_BLT:  jump = ($signed(a) < $signed(b));
                OP_BGT:  jump = ($signed(a) > $signed(b));
                OP_BLE:  jump = ($signed(a) <= $signed(b));
                OP_BGE:  jump = ($signed(a) >= $signed(b));
                OP_JAL:
                begin
                    reg_wr(rd, {20'd0, pc_q + 12'd1});
                    jump = 1'b1;
                end
                OP_LW:   reg_wr(rd, dmem_q[sum[11:0]] + c);
                OP_SW:   dmem_q[sum[11:0]] = c + d;
                OP_IN:
                    if (sum < NUM_IO_DEF)
                    begin
                        r.io_value = io_q[sum];
                        reg_wr(rd, r.io_value);
                        r.io_read = 1'b1;
                        r.io_index = sum[IO_IDX_W-1:0];
                    end
                OP_OUT:
                    if (sum < NUM_IO_DEF)
                    begin
                        io_q[sum] = c;
                        r.io_write = 1'b1;
                        r.io_index = sum[IO_IDX_W-1:0];
                        r.io_value = c;
                    end
                OP_HALT: r.status = ST_HALT;
                default: ;
            endcase
            if (op == OP_RETI)
                pc_q = io_q[IO_RETI_IDX][PC_W-1:0];
            else if (jump)
                pc_q = c[PC_W-1:0];
            else if (op != OP_HALT)
                pc_q = pc_q + 12'd1;
        end
        r.pc_now = pc_q;
    endtask

    task automatic check_field(input string name, input logic [XLEN-1:0] exp_v,
                               input logic [XLEN-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    initial
    begin
        fail_count = 0;
        outstanding = 0;
        pc_q = '0;
        for (int i = 0; i < NUM_REGS; i++)
            regs_q[i] = '0;
        for (int i = 0; i < NUM_IO_DEF; i++)
            io_q[i] = '0;
        for (int i = 0; i < DATA_DEPTH_DEF; i++)
            dmem_q[i] = '0;
    end

    always @(posedge clk)
    begin
        core_result_t r, e;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result word with nothing expected", $time);
                    fail_count++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    check_field("status", XLEN'(e.status), XLEN'(status));
                    check_field("pc_now", XLEN'(e.pc_now), XLEN'(pc_now));
                    check_field("read_value", e.read_value, read_value);
                    check_field("io_read", XLEN'(e.io_read), XLEN'(io_read));
                    check_field("io_write", XLEN'(e.io_write), XLEN'(io_write));
                    check_field("io_index", XLEN'(e.io_index), XLEN'(io_index));
                    check_field("io_value", e.io_value, io_value);
                end
            end
            if (in_valid && !in_stall)
            begin
                execute_word(func, instr_word, mem_address, write_value, reg_index, r);
                expected_results.push_back(r);
            end
            outstanding = expected_results.size();
        end
    end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import rie_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int PRELOAD_WORDS = 64;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [1:0]          func;
    logic [INSTR_W-1:0]  instr_word;
    logic [MADDR_W-1:0]  mem_address;
    logic [XLEN-1:0]     write_value;
    logic [REG_AW-1:0]   reg_index;
    logic                out_valid;
    logic                out_stall;
    logic [1:0]          status;
    logic [PC_W-1:0]     pc_now;
    logic [XLEN-1:0]     read_value;
    logic                io_read;
    logic                io_write;
    logic [IO_IDX_W-1:0] io_index;
    logic [XLEN-1:0]     io_value;
    int                  fail_count;
    int                  outstanding;
    int                  send_idle_pct;
    int                  recv_idle_pct;
    bit                  hold_request;
    int                  hold_left;
    int                  cycle_count;

    risc_instruction_execute_core i_dut (.*);

    rie_scoreboard i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // Receiver side: random stalls, or a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = 80;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    function automatic logic [INSTR_W-1:0] encode(input logic [7:0] op,
            input logic [3:0] rd, input logic [3:0] rs, input logic [3:0] rt,
            input logic [3:0] rm, input logic [11:0] imm1, input logic [11:0] imm2);
        return {op, rd, rs, rt, rm, imm1, imm2};
    endfunction

    task automatic send_word(input logic [1:0] fn, input logic [INSTR_W-1:0] iw,
                             input logic [MADDR_W-1:0] addr, input logic [XLEN-1:0] wv,
                             input logic [REG_AW-1:0] ri);
        in_valid <= 1'b1;
        func <= fn;
        instr_word <= iw;
        mem_address <= addr;
        write_value <= wv;
        reg_index <= ri;
        do
            @(posedge clk);
        while (in_stall);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
    endtask

    task automatic exec(input logic [INSTR_W-1:0] iw);
        send_word(FN_EXEC, iw, MADDR_W'($urandom), $urandom, REG_AW'($urandom));
    endtask

    task automatic send_random_word();
        logic [7:0]         op;
        logic [11:0]        imm1, imm2;
        logic [REG_AW-1:0]  rs_sel, rt_sel;
        logic [INSTR_W-1:0] iw;
        int                 pick;
        pick = $urandom_range(99);
        if (pick < 8)
            send_word(FN_MWR, INSTR_W'($urandom), MADDR_W'($urandom), $urandom,
                      REG_AW'($urandom));
        else if (pick < 16)
            send_word(FN_MRD, INSTR_W'({$urandom, $urandom}),
                      MADDR_W'($urandom_range(PRELOAD_WORDS - 1)), $urandom,
                      REG_AW'($urandom));
        else if (pick < 24)
            send_word(FN_RREG, INSTR_W'({$urandom, $urandom}), MADDR_W'($urandom),
                      $urandom, REG_AW'($urandom));
        else if (pick < 28)
        begin
            iw = INSTR_W'({$urandom, $urandom});
            // A load from an arbitrary address could hit a word that was never written.
            if (iw[47:40] == OP_LW)
                iw[47:40] = OP_SW;
            exec(iw);
        end
        else
        begin
            op = ($urandom_range(9) == 0) ? 8'($urandom_range(255, 22))
                                           : 8'($urandom_range(21));
            // Small immediates keep I/O indexes and shift amounts in interesting ranges.
            imm1 = $urandom_range(1) ? 12'($urandom_range(40)) : 12'($urandom);
            imm2 = $urandom_range(1) ? 12'($urandom_range(40)) : 12'($urandom);
            rs_sel = REG_AW'($urandom);
            rt_sel = REG_AW'($urandom);
            // Loads add two small immediates, so they stay inside the preloaded words.
            if (op == OP_LW)
            begin
                rs_sel = 4'd1;
                rt_sel = 4'd2;
                imm1 = 12'($urandom_range(31));
                imm2 = 12'($urandom_range(31));
            end
            exec(encode(op, 4'($urandom), rs_sel, rt_sel, 4'($urandom), imm1, imm2));
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (outstanding != 0);
        @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = FN_EXEC;
        instr_word = '0;
        mem_address = '0;
        write_value = '0;
        reg_index = '0;
        out_stall = 1'b0;
        hold_request = 1'b0;
        hold_left = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the low data words; every later read stays inside them or behind a store.
        for (int i = 0; i < PRELOAD_WORDS; i++)
            send_word(FN_MWR, '0, MADDR_W'(i), $urandom, '0);

        send_idle_pct = 30;
        recv_idle_pct = 52;
        send_word(FN_MWR, '0, 12'hfff, 32'hffffffff, '0);
        send_word(FN_MRD, '1, 12'hfff, '0, '0);
        send_word(FN_RREG, '0, '0, '0, 4'd0);
        exec('1);
        exec(encode(8'd22, 0, 0, 0, 0, 0, 0));
        for (int op = OP_ADD; op <= OP_SRL; op++)
            exec(encode(8'(op), 4'(3 + op), 1, 2, 1, 12'h800, 12'h7ff));
        // Shift by exactly 32 and by zero, negative operand.
        exec(encode(OP_SRA, 4, 2, 1, 0, 12'd32, 12'h800));
        exec(encode(OP_SLL, 5, 2, 1, 0, 12'd0, 12'hfff));
        exec(encode(OP_ADD, 0, 1, 2, 1, 12'd5, 12'd6));
        for (int op = OP_BEQ; op <= OP_BGE; op++)
            exec(encode(8'(op), 0, 1, 2, 2, 12'hfff, 12'h010));
        exec(encode(OP_JAL, 2, 0, 0, 2, 12'd0, 12'h040));
        exec(encode(OP_SW, 6, 1, 2, 3, 12'd100, 12'd20));
        exec(encode(OP_LW, 7, 1, 2, 3, 12'd100, 12'd20));
        exec(encode(OP_OUT, 0, 1, 0, 2, 12'd7, 12'h123));
        exec(encode(OP_OUT, 0, 1, 0, 2, 12'd22, 12'h456));
        exec(encode(OP_OUT, 0, 1, 0, 2, 12'd23, 12'h789));
        exec(encode(OP_IN, 8, 1, 0, 0, 12'd22, 12'd0));
        exec(encode(OP_IN, 9, 1, 2, 0, 12'hfff, 12'd0));
        exec(encode(OP_RETI, 0, 0, 0, 0, 0, 0));
        exec(encode(OP_HALT, 0, 0, 0, 0, 12'h555, 12'haaa));
        send_word(FN_RREG, '0, '0, '0, 4'd15);

        for (int i = 0; i < 120; i++)
        begin
            if (i == 40)
                hold_request = 1'b1;
            send_random_word();
        end
        in_valid <= 1'b0;
        wait_drained();

        send_idle_pct = 52;
        recv_idle_pct = 30;
        for (int i = 0; i < 120; i++)
            send_random_word();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 120; i++)
            send_random_word();
        in_valid <= 1'b0;

        wait_drained();
        repeat (10)
            @(posedge clk);
        if (fail_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/rie_pkg.sv
design/rie_ram.sv
design/risc_instruction_execute_core.sv
design/rie_checker.sv
verif/rie_checker.sv
verif/tb.sv
